// ===== hw/rtl/pfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, codes and constants for the Playfair digraph encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int unsigned SQUARE_SIDE = 5;
    localparam int unsigned SQUARE_SIZE = 25;

    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_TEXT   = 2'd2;

    localparam logic [4:0] PAD_LETTER = 5'd23;
    localparam logic [4:0] Q_LETTER   = 5'd16;
    localparam logic [6:0] ASCII_A    = 7'h41;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_byte;
    } in_item_t;

    typedef struct packed {
        logic [6:0] first_cipher;
        logic [6:0] second_cipher;
    } out_item_t;

    typedef struct packed {
        logic load_in;
        logic place_key;
        logic fill_step;
        logic set_ready;
        logic pend_set;
        logic pend_clear;
        logic pair_issue;
        logic pad_b;
        logic cell_issue;
        logic out_load;
    } pfe_cmd_t;

    typedef struct packed {
        logic kind_key;
        logic kind_finish;
        logic kind_text;
        logic is_letter;
        logic is_flush;
        logic same_letter;
        logic square_ready;
        logic pending_valid;
        logic fill_last;
        logic out_free;
    } pfe_status_t;

    // fill alphabet without q: position n maps to letter n below q, n+1 from q on
    function automatic logic [4:0] alpha_letter(input logic [4:0] n);
        alpha_letter = (n < Q_LETTER) ? n : 5'(n + 5'd1);
    endfunction

endpackage

// ===== hw/rtl/pfe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ctrl
// Controller state machine: sequences decode, alphabet fill, lookup and output.
// ----------------------------------------------------------------------------
module pfe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfe_pkg::pfe_status_t st,
    output pfe_pkg::pfe_cmd_t    cmd
);
    import pfe_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_FILL   = 5'b00100,
        ST_POS    = 5'b01000,
        ST_CELL   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                if (st.kind_key)
                begin
                    cmd.place_key = 1'b1;
                end
                else if (st.kind_finish && !st.square_ready)
                begin
                    state_next = ST_FILL;
                end
                else if (st.kind_text && st.square_ready)
                begin
                    if (st.pending_valid && (st.is_flush || st.is_letter))
                    begin
                        cmd.pair_issue = 1'b1;
                        cmd.pad_b      = st.is_flush || st.same_letter;
                        cmd.pend_clear = !st.same_letter;
                        state_next     = ST_POS;
                    end
                    else if (!st.pending_valid && st.is_letter)
                    begin
                        cmd.pend_set = 1'b1;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (st.fill_last)
                begin
                    cmd.set_ready = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_POS:
            begin
                cmd.cell_issue = 1'b1;
                state_next     = ST_CELL;
            end
            ST_CELL:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pfe_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_datapath
// Key square storage, letter positions, pending letter and output register.
// ----------------------------------------------------------------------------
module pfe_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfe_pkg::in_item_t    in_data,
    input  pfe_pkg::pfe_cmd_t    cmd,
    output pfe_pkg::pfe_status_t st,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pfe_pkg::out_item_t   out_data
);
    import pfe_pkg::*;

    in_item_t    in_item_reg;
    logic [25:0] seen_reg;
    logic [4:0]  fill_count_reg;
    logic [2:0]  row_reg;
    logic [2:0]  col_reg;
    logic [4:0]  alpha_cnt_reg;
    logic        square_ready_reg;
    logic        pending_valid_reg;
    logic [4:0]  pending_letter_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    logic [5:0]  pos_mem [26];
    logic [4:0]  cell_mem [25];

    logic [5:0]  pos_a_reg;
    logic [5:0]  pos_b_reg;
    logic        seen_a_reg;
    logic        seen_b_reg;
    logic [4:0]  cell_a_reg;
    logic [4:0]  cell_b_reg;

    logic        in_letter;
    logic [4:0]  in_idx;
    logic [4:0]  place_idx;
    logic        place_en;
    logic [4:0]  addr_b;
    logic [5:0]  pos_a;
    logic [5:0]  pos_b;
    logic [2:0]  ra;
    logic [2:0]  ca;
    logic [2:0]  rb;
    logic [2:0]  cb;
    logic [4:0]  k_a;
    logic [4:0]  k_b;

    function automatic logic [2:0] inc5(input logic [2:0] v);
        inc5 = (v == 3'(SQUARE_SIDE - 1)) ? 3'd0 : 3'(v + 3'd1);
    endfunction

    function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
        cell_index = 5'({2'b00, r} << 2) + 5'({2'b00, r}) + 5'({2'b00, c});
    endfunction

    // letter fold
    always_comb
    begin
        in_letter = 1'b0;
        in_idx    = 5'd0;
        if (in_item_reg.char_byte inside {[8'h41:8'h5A]})
        begin
            in_letter = 1'b1;
            in_idx    = 5'(in_item_reg.char_byte - 8'h41);
        end
        else if (in_item_reg.char_byte inside {[8'h61:8'h7A]})
        begin
            in_letter = 1'b1;
            in_idx    = 5'(in_item_reg.char_byte - 8'h61);
        end
    end

    assign place_idx = cmd.fill_step ? alpha_letter(alpha_cnt_reg) : in_idx;
    assign place_en  = (cmd.fill_step || (cmd.place_key && !square_ready_reg && in_letter))
                       && !seen_reg[place_idx]
                       && (fill_count_reg < 5'(SQUARE_SIZE));
    assign addr_b    = cmd.pad_b ? PAD_LETTER : in_idx;

    always_comb
    begin
        st               = '0;
        st.kind_key      = (in_item_reg.kind == KIND_KEY);
        st.kind_finish   = (in_item_reg.kind == KIND_FINISH);
        st.kind_text     = (in_item_reg.kind == KIND_TEXT);
        st.is_letter     = in_letter;
        st.is_flush      = (in_item_reg.char_byte == 8'h00);
        st.same_letter   = in_letter && (in_idx == pending_letter_reg);
        st.square_ready  = square_ready_reg;
        st.pending_valid = pending_valid_reg;
        st.fill_last     = (alpha_cnt_reg == 5'(SQUARE_SIZE - 1));
        st.out_free      = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg           <= '0;
            fill_count_reg     <= '0;
            row_reg            <= '0;
            col_reg            <= '0;
            alpha_cnt_reg      <= '0;
            square_ready_reg   <= 1'b0;
            pending_valid_reg  <= 1'b0;
            pending_letter_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (place_en)
            begin
                seen_reg[place_idx] <= 1'b1;
                fill_count_reg      <= 5'(fill_count_reg + 5'd1);
                col_reg             <= inc5(col_reg);
                if (col_reg == 3'(SQUARE_SIDE - 1))
                begin
                    row_reg <= 3'(row_reg + 3'd1);
                end
            end
            if (cmd.fill_step)
            begin
                alpha_cnt_reg <= 5'(alpha_cnt_reg + 5'd1);
            end
            if (cmd.set_ready)
            begin
                square_ready_reg <= 1'b1;
            end
            if (cmd.pend_set)
            begin
                pending_valid_reg  <= 1'b1;
                pending_letter_reg <= in_idx;
            end
            else if (cmd.pend_clear)
            begin
                pending_valid_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // position memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            pos_mem[place_idx] <= {row_reg, col_reg};
        end
        if (cmd.pair_issue)
        begin
            pos_a_reg  <= pos_mem[pending_letter_reg];
            pos_b_reg  <= pos_mem[addr_b];
            seen_a_reg <= seen_reg[pending_letter_reg];
            seen_b_reg <= seen_reg[addr_b];
        end
    end

    // letters absent from the square sit at row 0 column 0
    assign pos_a = seen_a_reg ? pos_a_reg : 6'd0;
    assign pos_b = seen_b_reg ? pos_b_reg : 6'd0;
    assign ra    = pos_a[5:3];
    assign ca    = pos_a[2:0];
    assign rb    = pos_b[5:3];
    assign cb    = pos_b[2:0];

    always_comb
    begin
        if (ra == rb)
        begin
            k_a = cell_index(ra, inc5(ca));
            k_b = cell_index(rb, inc5(cb));
        end
        else if (ca == cb)
        begin
            k_a = cell_index(inc5(ra), ca);
            k_b = cell_index(inc5(rb), cb);
        end
        else
        begin
            k_a = cell_index(ra, cb);
            k_b = cell_index(rb, ca);
        end
    end

    // square cell memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            cell_mem[fill_count_reg] <= place_idx;
        end
        if (cmd.cell_issue)
        begin
            cell_a_reg <= cell_mem[k_a];
            cell_b_reg <= cell_mem[k_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.first_cipher  <= 7'({2'b00, cell_a_reg}) + ASCII_A;
            out_data_reg.second_cipher <= 7'({2'b00, cell_b_reg}) + ASCII_A;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/playfair_digraph_encryptor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor
// Streaming Playfair encryptor with a 5 by 5 key square.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A key letter, a plaintext letter that
// only waits for its partner, or any ignored item is decoded and then ready
// returns. A finish-key transaction walks the 25-letter alphabet through the
// square's single write port, one letter a cycle. A transaction that completes
// a pair goes through decode, then a registered read of both letter positions,
// then a registered read of both square cells. The pair lands in an output
// register, so the next transaction is taken while it waits; if a further pair
// is ready before the held one is taken, the block holds until the output
// register frees.
module playfair_digraph_encryptor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pfe_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pfe_pkg::out_item_t out_data
);
    import pfe_pkg::*;

    pfe_cmd_t    cmd;
    pfe_status_t st;

    pfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    pfe_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/pfe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks for the Playfair digraph encryptor, bound to the top level.
// ----------------------------------------------------------------------------
module pfe_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input pfe_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input pfe_pkg::out_item_t out_data
);
    import pfe_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // cipher letters are upper case
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.first_cipher >= 7'h41) && (out_data.first_cipher <= 7'h5A)
                   && (out_data.second_cipher >= 7'h41) && (out_data.second_cipher <= 7'h5A))
        else $error("cipher letter out of range");

    // one transaction in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after accept");

    // a new result only comes out of work in progress
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");

    // no new result in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind playfair_digraph_encryptor pfe_checker u_pfe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
